@@ design/srrr_pkg.sv @@
// ----------------------------------------------------------------------------
// srrr_pkg
// Shared types and constants of the sonar round robin ranger core: word
// layouts of both stream channels, register map and distance arithmetic.
// ----------------------------------------------------------------------------
package srrr_pkg;

    // field widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WIDTH_W  = 16;
    localparam int unsigned SENSOR_W = 3;
    localparam int unsigned RANGE_W  = 13;
    localparam int unsigned CFG_W    = 16;

    // stream word widths, padded to whole bytes
    localparam int unsigned IN_BITS   = TIME_W + 1 + WIDTH_W;
    localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_BITS  = 2 + 2 * SENSOR_W + 2 * RANGE_W;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // apb port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // register map, selected by paddr[2]
    typedef enum logic {
        REG_ECHO_TIMEOUT = 1'b0,
        REG_PING_GAP     = 1'b1
    } reg_sel_t;

    localparam logic [CFG_W-1:0] ECHO_TIMEOUT_RST = 16'd40;
    localparam logic [CFG_W-1:0] PING_GAP_RST     = 16'd20;

    // distance = width*10/148 + 2, the divide done by reciprocal multiply;
    // exact for every 20-bit dividend since (m*148 - 2^28) * 2^20 < 2^28
    localparam int unsigned DIST_SHIFT = 28;
    localparam int unsigned DIST_DEN   = 148;
    localparam logic [20:0] DIST_RECIP = 21'((64'd1 << DIST_SHIFT) / DIST_DEN + 1);
    localparam logic [RANGE_W-1:0] DIST_OFFSET  = 13'd2;
    localparam logic [RANGE_W-1:0] DIST_TIMEOUT = 13'd4000;
    localparam logic [RANGE_W-1:0] RANGE_MAX    = 13'd4430;

    // input word, last field in the lowest bits
    typedef struct packed {
        logic [WIDTH_W-1:0] echo_width_us;
        logic               echo_seen;
        logic [TIME_W-1:0]  now_ms;
    } in_word_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [RANGE_W-1:0]  range_average;
        logic [RANGE_W-1:0]  range_value;
        logic [SENSOR_W-1:0] reading_sensor;
        logic                reading_valid;
        logic [SENSOR_W-1:0] ping_sensor;
        logic                ping_fire;
    } out_word_t;

endpackage

@@ design/sonar_round_robin_ranger_core.sv @@
// ----------------------------------------------------------------------------
// sonar_round_robin_ranger_core
// Round robin sequencer for a set of ultrasonic rangers: decides when to
// ping, turns echo widths into distances and keeps a running average.
// ----------------------------------------------------------------------------
// The core takes one update word per clock while the result side is not
// stalled and returns exactly one result word for each: the word is held in
// the input register, then the decision, distance and average logic writes
// the result register together with the sequencer state, so the next word
// already sees the updated state. The critical path is the reciprocal
// multiply of the echo width followed by the average add. Stalls on the
// result side hold the result register and back up into the input register;
// the input side keeps accepting as long as the result register can move.
module sonar_round_robin_ranger_core #(
    parameter int unsigned SENSOR_COUNT = 5
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] now_ms, [32] echo_seen, [48:33] echo_width_us, rest zero
    input  logic [srrr_pkg::IN_DATA_W-1:0]     s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] ping_fire, [3:1] ping_sensor, [4] reading_valid,
    // [7:5] reading_sensor, [20:8] range_value, [33:21] range_average,
    // rest zero
    output logic [srrr_pkg::OUT_DATA_W-1:0]    m_tdata,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srrr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [srrr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [srrr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import srrr_pkg::*;

    localparam int unsigned IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

    // configuration registers
    logic [CFG_W-1:0] echo_timeout_reg;
    logic [CFG_W-1:0] ping_gap_reg;

    // pipeline registers
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;

    // sequencer state
    logic                    awaiting_reg, awaiting_next;
    logic [IDX_W-1:0]        sensor_reg, sensor_next;
    logic [TIME_W-1:0]       last_ping_reg, last_ping_next;
    logic [RANGE_W-1:0]      avg_reg [SENSOR_COUNT];

    logic                    advance;
    logic                    cfg_write;
    reg_sel_t                cfg_sel;
    logic [TIME_W-1:0]       elapsed;
    logic                    gap_met;
    logic                    timeout_met;
    logic [19:0]             width_x10;
    logic [40:0]             recip_prod;
    logic [RANGE_W-1:0]      echo_dist;
    logic [RANGE_W-1:0]      avg_cur;
    logic [RANGE_W+1:0]      avg_sum;
    logic                    done;
    logic [RANGE_W-1:0]      new_dist;
    logic [RANGE_W-1:0]      avg_new;
    out_word_t               out_word_next;

    // apb: writes complete in the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_sel   = reg_sel_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_sel)
            REG_ECHO_TIMEOUT: prdata = APB_DATA_W'(echo_timeout_reg);
            REG_PING_GAP:     prdata = APB_DATA_W'(ping_gap_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_timeout_reg <= ECHO_TIMEOUT_RST;
            ping_gap_reg     <= PING_GAP_RST;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_ECHO_TIMEOUT: echo_timeout_reg <= pwdata[CFG_W-1:0];
                REG_PING_GAP:     ping_gap_reg     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: input register moves whenever the result register can take a word
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_word_reg);

    // timing compares, modulo 2^32
    assign elapsed     = in_word_reg.now_ms - last_ping_reg;
    assign gap_met     = elapsed >= TIME_W'(ping_gap_reg);
    assign timeout_met = elapsed >= TIME_W'(echo_timeout_reg);

    // echo distance: width*10 by shifts, /148 by reciprocal multiply
    assign width_x10  = (20'(in_word_reg.echo_width_us) << 3)
                      + (20'(in_word_reg.echo_width_us) << 1);
    assign recip_prod = 41'(width_x10) * 41'(DIST_RECIP);
    assign echo_dist  = recip_prod[40:28] + DIST_OFFSET;

    // a captured echo wins over a timeout
    assign new_dist = in_word_reg.echo_seen ? echo_dist : DIST_TIMEOUT;

    // running average (avg*3 + d)/4
    assign avg_cur = avg_reg[sensor_reg];
    assign avg_sum = (15'(avg_cur) << 1) + 15'(avg_cur) + 15'(new_dist);
    assign avg_new = avg_sum[RANGE_W+1:2];

    // step decision
    always_comb begin
        awaiting_next  = awaiting_reg;
        sensor_next    = sensor_reg;
        last_ping_next = last_ping_reg;
        out_word_next  = '0;
        done           = 1'b0;

        if (!awaiting_reg) begin
            if (gap_met) begin
                out_word_next.ping_fire   = 1'b1;
                out_word_next.ping_sensor = SENSOR_W'(sensor_reg);
                last_ping_next            = in_word_reg.now_ms;
                awaiting_next             = 1'b1;
            end
        end else begin
            done = in_word_reg.echo_seen || timeout_met;
            if (done) begin
                out_word_next.reading_valid  = 1'b1;
                out_word_next.reading_sensor = SENSOR_W'(sensor_reg);
                out_word_next.range_value    = new_dist;
                out_word_next.range_average  = avg_new;
                awaiting_next                = 1'b0;
                sensor_next = (sensor_reg == LAST_IDX) ? '0 : sensor_reg + 1'b1;
                // immediate ping of the next sensor when the gap has passed
                if (gap_met) begin
                    out_word_next.ping_fire   = 1'b1;
                    out_word_next.ping_sensor = SENSOR_W'(sensor_next);
                    last_ping_next            = in_word_reg.now_ms;
                    awaiting_next             = 1'b1;
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
            sensor_reg    <= '0;
            last_ping_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                awaiting_reg  <= awaiting_next;
                sensor_reg    <= sensor_next;
                last_ping_reg <= last_ping_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-sensor averages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                avg_reg[i] <= '0;
            end
        end else if (advance && done) begin
            avg_reg[sensor_reg] <= avg_new;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= in_word_t'(s_tdata[IN_BITS-1:0]);
        end
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

@@ design/srrr_checker.sv @@
// ----------------------------------------------------------------------------
// srrr_checker
// Port-level checks of the sonar round robin ranger core, bound to the top.
// ----------------------------------------------------------------------------
module srrr_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [srrr_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                               pready
);
    import srrr_pkg::*;

    out_word_t word;
    assign word = out_word_t'(m_tdata[OUT_BITS-1:0]);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // no reading: sensor, value and average all zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !word.reading_valid |->
            word.reading_sensor == '0 && word.range_value == '0 &&
            word.range_average == '0)
        else $error("reading fields set without a reading");

    // no ping: ping sensor zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !word.ping_fire |-> word.ping_sensor == '0)
        else $error("ping sensor set without a ping");

    // readings and averages stay within the distance range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && word.reading_valid |->
            word.range_value <= RANGE_MAX && word.range_average <= RANGE_MAX)
        else $error("range out of bounds");

    // config port never inserts wait states
    assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind sonar_round_robin_ranger_core srrr_checker u_srrr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

@@ test/tb_sonar_round_robin_ranger_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sonar_round_robin_ranger_core
// Self-checking bench for the sonar round robin ranger core. A queue of
// update words feeds a stream driver, a clocked predictor tracks the
// ping/echo sequencer and its per-sensor averages, and every result word is
// checked field by field. Register settings are changed over the APB port
// between phases, from the reset values to zero and full-scale extremes.
// ----------------------------------------------------------------------------
module tb_sonar_round_robin_ranger_core;

    import srrr_pkg::*;

    localparam int unsigned N_SENSORS   = 5;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ECHO_SCALE  = 10;
    localparam int unsigned ECHO_DIV    = 148;
    localparam int unsigned AVG_WEIGHT  = 3;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    sonar_round_robin_ranger_core #(
        .SENSOR_COUNT(N_SENSORS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // stimulus and expectation stores
    in_word_t    pending_updates[$];
    out_word_t   range_expect[$];
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned idle_pct     = 0;
    int unsigned in_gap_left  = 0;
    int unsigned out_stall_left = 0;
    logic        in_taken     = 1'b0;
    logic [TIME_W-1:0] gen_time = '0;

    // predicted sequencer state and register copies
    logic [CFG_W-1:0]    cfg_timeout = ECHO_TIMEOUT_RST;
    logic [CFG_W-1:0]    cfg_gap     = PING_GAP_RST;
    logic                pend_echo   = 1'b0;
    logic [SENSOR_W-1:0] cur_sensor  = '0;
    logic [TIME_W-1:0]   last_ping   = '0;
    int unsigned         avg_mem[N_SENSORS] = '{default: 0};

    // one update through the sequencer, returns the expected result word
    function automatic out_word_t range_predict(in_word_t w);
        out_word_t         r;
        logic [TIME_W-1:0] elapsed;
        int unsigned       new_dist;
        int unsigned       slot;
        bit                done;
        r        = '0;
        new_dist = 0;
        done     = 1'b0;
        elapsed  = w.now_ms - last_ping;
        if (!pend_echo) begin
            if (elapsed >= TIME_W'(cfg_gap)) begin
                r.ping_fire   = 1'b1;
                r.ping_sensor = cur_sensor;
                last_ping     = w.now_ms;
                pend_echo     = 1'b1;
            end
        end else begin
            // a captured echo beats a timeout in the same update
            if (w.echo_seen) begin
                new_dist = (32'(w.echo_width_us) * ECHO_SCALE) / ECHO_DIV
                           + 32'(DIST_OFFSET);
                done = 1'b1;
            end else if (elapsed >= TIME_W'(cfg_timeout)) begin
                new_dist = 32'(DIST_TIMEOUT);
                done = 1'b1;
            end
            if (done) begin
                slot             = cur_sensor;
                avg_mem[slot]    = (avg_mem[slot] * AVG_WEIGHT + new_dist) / 4;
                r.reading_valid  = 1'b1;
                r.reading_sensor = SENSOR_W'(slot);
                r.range_value    = RANGE_W'(new_dist);
                r.range_average  = RANGE_W'(avg_mem[slot]);
                cur_sensor       = SENSOR_W'((slot + 1) % N_SENSORS);
                pend_echo        = 1'b0;
                // next sensor goes out at once if the gap since the old ping is over
                if (elapsed >= TIME_W'(cfg_gap)) begin
                    r.ping_fire   = 1'b1;
                    r.ping_sensor = cur_sensor;
                    last_ping     = w.now_ms;
                    pend_echo     = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (in_gap_left > 0) begin
                s_tvalid <= 1'b0;
                in_gap_left--;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                s_tvalid <= 1'b0;
                in_gap_left = $urandom_range(0, 7);
            end else if (pending_updates.size() != 0) begin
                s_tdata  <= IN_DATA_W'(pending_updates.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side back pressure
    always @(negedge aclk) begin
        if (out_stall_left > 0) begin
            m_tready <= 1'b0;
            out_stall_left--;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            m_tready <= 1'b0;
            out_stall_left = $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: check results, predict accepted updates
    always @(posedge aclk) begin : monitor_blk
        out_word_t want;
        out_word_t got;
        in_word_t  upd;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_BITS-1:0];
                if (range_expect.size() == 0) begin
                    $display("%0t ns: unexpected result word, expected none, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = range_expect.pop_front();
                    check_field("ping_fire", want.ping_fire, got.ping_fire);
                    check_field("ping_sensor", want.ping_sensor, got.ping_sensor);
                    check_field("reading_valid", want.reading_valid, got.reading_valid);
                    check_field("reading_sensor", want.reading_sensor, got.reading_sensor);
                    check_field("range_value", want.range_value, got.range_value);
                    check_field("range_average", want.range_average, got.range_average);
                end
            end
            if (s_tvalid && s_tready) begin
                upd = s_tdata[IN_BITS-1:0];
                range_expect.push_back(range_predict(upd));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_update(input logic [TIME_W-1:0] now, input logic echo,
                               input logic [WIDTH_W-1:0] width_us);
        in_word_t w;
        w.now_ms        = now;
        w.echo_seen     = echo;
        w.echo_width_us = width_us;
        pending_updates.push_back(w);
    endtask

    // mostly steady time with random echoes, a few jumps anywhere on the clock
    task automatic queue_random(input int unsigned count, input int unsigned max_step,
                                input int unsigned echo_pct);
        logic [WIDTH_W-1:0] width_us;
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 2) begin
                gen_time = $urandom();
            end else begin
                gen_time += $urandom_range(0, max_step);
            end
            if ($urandom_range(0, 99) < 30) begin
                width_us = $urandom_range(0, 65535);
            end else begin
                width_us = $urandom_range(0, 1600);
            end
            push_update(gen_time, $urandom_range(0, 99) < echo_pct, width_us);
        end
    endtask

    // every result in before the registers change
    task automatic wait_drained();
        while (pending_updates.size() != 0 || s_tvalid || range_expect.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // register write followed by a read back
    task automatic reg_write_check(input reg_sel_t sel, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == REG_ECHO_TIMEOUT) begin
            cfg_timeout = value;
        end else begin
            cfg_gap = value;
        end
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[CFG_W-1:0] !== value) begin
            $display("%0t ns: register %s read back, expected %0d, actual %0d",
                     $time, sel.name(), value, prdata[CFG_W-1:0]);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        // directed part, reset settings: timeout 40, gap 20
        push_update(32'd0, 1'b0, 16'd0);              // gap not yet over
        push_update(32'd19, 1'b1, 16'hFFFF);          // echo while waiting to ping
        push_update(32'd20, 1'b0, 16'd0);             // ping sensor 0
        push_update(32'd25, 1'b1, 16'hFFFF);          // widest echo, no re-ping
        push_update(32'd45, 1'b0, 16'd0);             // ping sensor 1
        push_update(32'd85, 1'b0, 16'd0);             // timeout, immediate re-ping
        push_update(32'd125, 1'b1, 16'd0);            // echo and timeout together
        push_update(32'd126, 1'b1, 16'd148);
        push_update(32'hFFFF_FFF0, 1'b0, 16'd0);      // ping near the top of time
        push_update(32'h0000_0010, 1'b1, 16'd1480);   // time wraps, re-ping
        push_update(32'h0000_0011, 1'b1, 16'h8000);
        push_update(32'h7FFF_FFFF, 1'b0, 16'h5555);
        push_update(32'h8000_0026, 1'b0, 16'h0000);   // one short of timeout
        push_update(32'h8000_0027, 1'b0, 16'h0000);   // timeout exactly
        push_update(32'h8000_0028, 1'b1, 16'h2AAA);
        gen_time = 32'h8000_0028;
        idle_pct = 20;
        queue_random(250, 8, 40);

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        // zero timeout and zero gap: every comparison passes
        reg_write_check(REG_ECHO_TIMEOUT, 16'd0);
        reg_write_check(REG_PING_GAP, 16'd0);
        idle_pct = 30;
        queue_random(150, 4, 30);
        wait_drained();

        // full-scale settings, large time steps
        reg_write_check(REG_ECHO_TIMEOUT, 16'hFFFF);
        reg_write_check(REG_PING_GAP, 16'hFFFF);
        idle_pct = 10;
        queue_random(150, 40000, 20);
        wait_drained();

        // random mid-range settings
        reg_write_check(REG_ECHO_TIMEOUT, CFG_W'($urandom_range(1, 100)));
        reg_write_check(REG_PING_GAP, CFG_W'($urandom_range(1, 100)));
        idle_pct = 15;
        queue_random(250, 30, 35);
        wait_drained();

        // short timeout, long gap, no idling to the end
        reg_write_check(REG_ECHO_TIMEOUT, 16'd3);
        reg_write_check(REG_PING_GAP, 16'd50);
        idle_pct = 0;
        queue_random(250, 12, 40);
        wait_drained();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
